### hw/rtl/mcwd_pkg.sv
// Package for the multi-channel watchdog table.
// Holds sizes, command and result codes, the result struct and index helpers.
// No dependencies.
`timescale 1ns / 1ps

package mcwd_pkg;

    // Table size and derived widths.
    localparam int CHANNELS    = 8;
    localparam int MAX_RESULTS = 8;
    localparam int IDX_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CNT_W       = $clog2(CHANNELS + 1);
    localparam int NUM_W       = $clog2(MAX_RESULTS + 1);
    localparam int DATA_W      = 32;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [2:0]       slot_t;

    // Input command codes.
    typedef enum logic [1:0] {
        CMD_TICK     = 2'd0,
        CMD_FEED     = 2'd1,
        CMD_REGISTER = 2'd2
    } cmd_t;

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_EXPIRED    = 2'd0,
        KIND_FED        = 2'd1,
        KIND_REGISTERED = 2'd2,
        KIND_REFUSED    = 2'd3
    } kind_t;

    // One result item as it travels to the output stage.
    typedef struct packed {
        kind_t kind;
        slot_t slot;
        logic  last;
    } result_t;

    // Controller states, one-hot.
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_CMD   = 4'b0010,
        ST_TICK  = 4'b0100,
        ST_FLUSH = 4'b1000
    } state_t;

    // Low three bits of a slot index, as reported in a result.
    function automatic slot_t to_slot(input idx_t idx);
        logic [IDX_W+2:0] ext;
        ext = {3'b000, idx};
        return ext[2:0];
    endfunction

    // Slot index addressed by a channel field.
    function automatic idx_t chan_to_idx(input logic [2:0] chan);
        logic [IDX_W+2:0] ext;
        ext = {{IDX_W{1'b0}}, chan};
        return ext[IDX_W-1:0];
    endfunction

    // True when the channel field names an existing slot.
    function automatic logic chan_ok(input logic [2:0] chan);
        logic [7:0] ext;
        ext = {5'b00000, chan};
        return ext < 8'(CHANNELS);
    endfunction

endpackage

### hw/rtl/mcwd_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module mcwd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write, and registered read; the read data holds when re is low.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### hw/rtl/mcwd_out_stage.sv
// Output register of the watchdog table: holds one result item until taken.
// Depends on mcwd_pkg.
`timescale 1ns / 1ps

module mcwd_out_stage import mcwd_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  result_t    push_res,
    output logic       room,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] kind,
    output logic [2:0] slot,
    output logic       last
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    // The stage can take a new item when empty or when its item leaves now.
    assign room = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (push)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            res_reg <= push_res;
        end
    end

    assign out_valid = valid_reg;
    assign kind      = res_reg.kind;
    assign slot      = res_reg.slot;
    assign last      = res_reg.last;

endmodule

### hw/rtl/mcwd_ctrl.sv
// Controller of the watchdog table: command sequencer, tick walk over the
// counter and limit memories, and result generation. Depends on mcwd_pkg, mcwd_ram.
`timescale 1ns / 1ps

module mcwd_ctrl import mcwd_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  cmd,
    input  logic [2:0]  channel,
    input  logic [31:0] limit,
    input  logic        room,
    output logic        push,
    output result_t     push_res
);

    state_t             state_reg, state_next;
    logic [1:0]         cmd_reg;
    idx_t               chan_reg;
    logic [DATA_W-1:0]  limit_reg;
    logic [CNT_W-1:0]   used_reg, used_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic               ev_valid_reg, ev_valid_next;
    idx_t               ev_idx_reg, ev_idx_next;
    logic               pend_valid_reg, pend_valid_next;
    idx_t               pend_idx_reg, pend_idx_next;
    logic [NUM_W-1:0]   n_reg, n_next;

    logic               cnt_we;
    idx_t               cnt_waddr;
    logic [DATA_W-1:0]  cnt_wdata;
    logic               lim_we;
    logic               rd_en;
    logic [DATA_W-1:0]  cnt_rdata;
    logic [DATA_W-1:0]  lim_rdata;
    logic [DATA_W-1:0]  cnt_inc;
    logic               expired;
    logic               report;
    logic               stall;
    logic               full;
    logic               accept;

    // Counter and limit stores share one read address.
    mcwd_ram #(.WIDTH(DATA_W), .DEPTH(CHANNELS)) u_count_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .re    (rd_en),
        .raddr (idx_reg[IDX_W-1:0]),
        .rdata (cnt_rdata)
    );

    mcwd_ram #(.WIDTH(DATA_W), .DEPTH(CHANNELS)) u_limit_ram (
        .clk   (clk),
        .we    (lim_we),
        .waddr (used_reg[IDX_W-1:0]),
        .wdata (limit_reg),
        .re    (rd_en),
        .raddr (idx_reg[IDX_W-1:0]),
        .rdata (lim_rdata)
    );

    // Saturating increment and expiry test of the slot whose data is out of the RAMs.
    assign cnt_inc = (cnt_rdata == {DATA_W{1'b1}}) ? cnt_rdata : cnt_rdata + 32'd1;
    assign expired = cnt_inc > lim_rdata;
    assign report  = ev_valid_reg && expired && (n_reg < NUM_W'(MAX_RESULTS));
    // A new expiry pushes out the held one; wait if the output stage is busy.
    assign stall   = report && pend_valid_reg && !room;
    assign full    = used_reg >= CNT_W'(CHANNELS);
    assign in_ready = (state_reg == ST_IDLE);
    assign accept  = in_valid && in_ready;

    // Sequencer.
    always_comb
    begin
        state_next      = state_reg;
        used_next       = used_reg;
        idx_next        = idx_reg;
        ev_valid_next   = ev_valid_reg;
        ev_idx_next     = ev_idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        n_next          = n_reg;
        push            = 1'b0;
        push_res        = '{kind: KIND_EXPIRED, slot: 3'd0, last: 1'b0};
        cnt_we          = 1'b0;
        cnt_waddr       = ev_idx_reg;
        cnt_wdata       = cnt_inc;
        lim_we          = 1'b0;
        rd_en           = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd)
                        CMD_TICK:
                        begin
                            state_next      = ST_TICK;
                            idx_next        = '0;
                            ev_valid_next   = 1'b0;
                            pend_valid_next = 1'b0;
                            n_next          = '0;
                        end
                        CMD_FEED:
                        begin
                            if (chan_ok(channel))
                            begin
                                state_next = ST_CMD;
                            end
                        end
                        CMD_REGISTER:
                        begin
                            state_next = ST_CMD;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            // Feed or register: update the store, unless a register is refused, and answer with one item.
            ST_CMD:
            begin
                if (room)
                begin
                    push       = 1'b1;
                    state_next = ST_IDLE;
                    if (cmd_reg == CMD_FEED)
                    begin
                        cnt_we    = 1'b1;
                        cnt_waddr = chan_reg;
                        cnt_wdata = '0;
                        push_res  = '{kind: KIND_FED, slot: to_slot(chan_reg), last: 1'b1};
                    end
                    else if (full)
                    begin
                        push_res = '{kind: KIND_REFUSED, slot: 3'd0, last: 1'b1};
                    end
                    else
                    begin
                        cnt_we    = 1'b1;
                        cnt_waddr = used_reg[IDX_W-1:0];
                        cnt_wdata = '0;
                        lim_we    = 1'b1;
                        used_next = used_reg + CNT_W'(1);
                        push_res  = '{kind: KIND_REGISTERED,
                                      slot: to_slot(used_reg[IDX_W-1:0]), last: 1'b1};
                    end
                end
            end

            // Walk the registered slots: read one, write back the previous one.
            ST_TICK:
            begin
                if (!stall)
                begin
                    if (ev_valid_reg)
                    begin
                        cnt_we = 1'b1;
                    end
                    if (report)
                    begin
                        if (pend_valid_reg)
                        begin
                            push     = 1'b1;
                            push_res = '{kind: KIND_EXPIRED, slot: to_slot(pend_idx_reg),
                                         last: 1'b0};
                        end
                        pend_valid_next = 1'b1;
                        pend_idx_next   = ev_idx_reg;
                        n_next          = n_reg + NUM_W'(1);
                    end
                    if (idx_reg < used_reg)
                    begin
                        rd_en         = 1'b1;
                        ev_valid_next = 1'b1;
                        ev_idx_next   = idx_reg[IDX_W-1:0];
                        idx_next      = idx_reg + CNT_W'(1);
                    end
                    else
                    begin
                        ev_valid_next = 1'b0;
                        if (!ev_valid_reg)
                        begin
                            state_next = ST_FLUSH;
                        end
                    end
                end
            end

            // The held expiry, if any, is the last item of this tick.
            ST_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (room)
                begin
                    push            = 1'b1;
                    push_res        = '{kind: KIND_EXPIRED, slot: to_slot(pend_idx_reg),
                                        last: 1'b1};
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            used_reg       <= '0;
            idx_reg        <= '0;
            ev_valid_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            n_reg          <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            used_reg       <= used_next;
            idx_reg        <= idx_next;
            ev_valid_reg   <= ev_valid_next;
            pend_valid_reg <= pend_valid_next;
            n_reg          <= n_next;
        end
    end

    // Payload registers: command fields and walk indexes.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= cmd;
            chan_reg  <= chan_to_idx(channel);
            limit_reg <= limit;
        end
        ev_idx_reg   <= ev_idx_next;
        pend_idx_reg <= pend_idx_next;
    end

    // The output stage is never loaded while it still holds an item.
    assert property (@(posedge clk) disable iff (!rst_n) push |-> room)
        else $error("result pushed into a full output stage");

    // The fill count never passes the table size.
    assert property (@(posedge clk) disable iff (!rst_n) used_reg <= CNT_W'(CHANNELS))
        else $error("slot count beyond table size");

    // No more expiries are recorded than may be reported on one tick.
    assert property (@(posedge clk) disable iff (!rst_n) n_reg <= NUM_W'(MAX_RESULTS))
        else $error("expiry count beyond limit");

    // The walk only evaluates registered slots.
    assert property (@(posedge clk) disable iff (!rst_n)
        ev_valid_reg |-> (CNT_W'(ev_idx_reg) < used_reg))
        else $error("walk evaluated an unregistered slot");

    // Nothing is left held once the block is back at rest.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !pend_valid_reg && !ev_valid_reg)
        else $error("tick state left behind on return to idle");

endmodule

### hw/rtl/multi_channel_watchdog_table_top.sv
// Top level of the multi-channel watchdog table.
// Depends on mcwd_pkg, mcwd_ctrl, mcwd_out_stage.
//
// Usage: items enter on the in_valid/in_ready channel with fields cmd, channel
// and limit. A tick item raises every registered counter by one and gives one
// expired item per counter above its limit (at most eight, in slot order, the
// final one marked last). A feed item clears one counter and answers fed; a
// register item takes the next free slot and answers registered, or refused
// when the table is full. Results leave on out_valid/out_ready as kind, slot
// and last.
// Sequence: a feed or register result enters the output register from ST_CMD,
// which waits there for room; the next item is taken once back in ST_IDLE.
// A tick puts its last result into the output register from ST_FLUSH and
// frees the input in the same cycle as that result shows on out_valid; with
// an empty table it gives no result. The walk reads one slot per cycle from
// the counter and limit memories, unless stalled, and writes each updated
// counter back on the step after its read. One item is handled at a time;
// in_ready returns once its last result has entered the output register.
// Reset clears the fill count and the controller; the memories are not cleared,
// there is no clearing pass. When the receiver stalls, the finished result waits
// in the output register and the tick walk pauses on the next expiry.
`timescale 1ns / 1ps

module multi_channel_watchdog_table_top import mcwd_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  cmd,
    input  logic [2:0]  channel,
    input  logic [31:0] limit,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [2:0]  slot,
    output logic        last
);

    logic    room;
    logic    push;
    result_t push_res;

    // Command sequencer and memories.
    mcwd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .channel  (channel),
        .limit    (limit),
        .room     (room),
        .push     (push),
        .push_res (push_res)
    );

    // Result register towards the receiver.
    mcwd_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_res  (push_res),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .kind      (kind),
        .slot      (slot),
        .last      (last)
    );

endmodule
